/* hw/rtl/vmir_pkg.sv */
`default_nettype none

package vmir_pkg;

    localparam int REQ_W  = 2;
    localparam int OFF_W  = 12;
    localparam int SIZE_W = 4;
    localparam int DATA_W = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVENT = 2'd2;

    // register offsets
    localparam logic [OFF_W-1:0] OFF_MAGIC         = 12'h000;
    localparam logic [OFF_W-1:0] OFF_VERSION       = 12'h004;
    localparam logic [OFF_W-1:0] OFF_DEVICE_ID     = 12'h008;
    localparam logic [OFF_W-1:0] OFF_VENDOR_ID     = 12'h00c;
    localparam logic [OFF_W-1:0] OFF_DEV_FEAT      = 12'h010;
    localparam logic [OFF_W-1:0] OFF_DEV_FEAT_SEL  = 12'h014;
    localparam logic [OFF_W-1:0] OFF_DRV_FEAT      = 12'h020;
    localparam logic [OFF_W-1:0] OFF_DRV_FEAT_SEL  = 12'h024;
    localparam logic [OFF_W-1:0] OFF_QUEUE_SEL     = 12'h030;
    localparam logic [OFF_W-1:0] OFF_QUEUE_NUM_MAX = 12'h034;
    localparam logic [OFF_W-1:0] OFF_QUEUE_NUM     = 12'h038;
    localparam logic [OFF_W-1:0] OFF_QUEUE_READY   = 12'h044;
    localparam logic [OFF_W-1:0] OFF_QUEUE_NOTIFY  = 12'h050;
    localparam logic [OFF_W-1:0] OFF_INT_STATUS    = 12'h060;
    localparam logic [OFF_W-1:0] OFF_INT_ACK       = 12'h064;
    localparam logic [OFF_W-1:0] OFF_STATUS        = 12'h070;
    localparam logic [OFF_W-1:0] OFF_DESC_LO       = 12'h080;
    localparam logic [OFF_W-1:0] OFF_DESC_HI       = 12'h084;
    localparam logic [OFF_W-1:0] OFF_AVAIL_LO      = 12'h090;
    localparam logic [OFF_W-1:0] OFF_AVAIL_HI      = 12'h094;
    localparam logic [OFF_W-1:0] OFF_USED_LO       = 12'h0a0;
    localparam logic [OFF_W-1:0] OFF_USED_HI       = 12'h0a4;
    localparam logic [OFF_W-1:0] OFF_CFG_GEN       = 12'h0fc;
    localparam logic [OFF_W-1:0] CFG_BASE          = 12'h100;
    localparam logic [OFF_W-1:0] CFG_END           = 12'h188;
    localparam logic [8:0]       CFG_BYTES         = 9'd136;

    localparam logic [DATA_W-1:0] MAGIC_VALUE = 32'h7472_6976;
    localparam logic [DATA_W-1:0] MMIO_VER    = 32'd2;
    localparam logic [DATA_W-1:0] DEVICE_ID   = 32'd18;
    localparam logic [DATA_W-1:0] VENDOR_ID   = 32'h0000_1af4;

    // device status bits
    localparam int ST_DRIVER_OK   = 2;
    localparam int ST_FEATURES_OK = 3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] access_size;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic              handled;
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
    } t_rsp;

endpackage

`default_nettype wire

/* hw/rtl/vmir_in_if.sv */
`default_nettype none

interface vmir_in_if;
    logic                        valid;
    logic                        ready;
    logic [vmir_pkg::REQ_W-1:0]  req_type;
    logic [vmir_pkg::OFF_W-1:0]  offset;
    logic [vmir_pkg::SIZE_W-1:0] access_size;
    logic [vmir_pkg::DATA_W-1:0] write_data;

    modport source (output valid, req_type, offset, access_size, write_data, input ready);
    modport sink   (input valid, req_type, offset, access_size, write_data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/vmir_out_if.sv */
`default_nettype none

interface vmir_out_if;
    logic                        valid;
    logic                        ready;
    logic                        handled;
    logic [vmir_pkg::DATA_W-1:0] read_data;
    logic                        irq_level;

    modport source (output valid, handled, read_data, irq_level, input ready);
    modport sink   (input valid, handled, read_data, irq_level, output ready);
endinterface

`default_nettype wire

/* hw/rtl/virtio_mmio_input_registers.sv */
// Path: an accepted item moves through the input register, then the response register;
//   decode and register update lie between them. A stalled response side holds the item.
// Throughput: one item per cycle while the response side is not stalled.
// Reset: i_rst_n synchronous active low; all registers, queues and the enable clear to zero,
//   except the queue-select flag (set to one); both pipeline registers empty. No clearing pass.
`default_nettype none

module virtio_mmio_input_registers #(
    parameter int QUEUE_MAX   = 64,
    parameter int QUEUE_COUNT = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    vmir_in_if.sink    i_req,
    vmir_out_if.source o_rsp
);
    import vmir_pkg::*;

    // device enable; the user must write it only while idle, the block does not enforce this
    logic r_dev_en;

    // stage 1: captured access
    logic r_in_valid;
    t_req r_in;

    // stage 2: response register
    logic r_out_valid;
    t_rsp r_out;

    t_rsp rsp;
    logic s1_go;
    logic in_take;

    // Stage 1 advances whenever the response register is empty or draining;
    // the register file commits state on the same edge.
    assign s1_go       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || s1_go;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_dev_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.req_type    <= i_req.req_type;
            r_in.offset      <= i_req.offset;
            r_in.access_size <= i_req.access_size;
            r_in.write_data  <= i_req.write_data;
        end
    end

    vmir_regs #(
        .QUEUE_MAX   (QUEUE_MAX),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_go),
        .i_dev_en (r_dev_en),
        .i_req    (r_in),
        .o_rsp    (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.handled   = r_out.handled;
    assign o_rsp.read_data = r_out.read_data;
    assign o_rsp.irq_level = r_out.irq_level;

`ifndef SYNTHESIS
    // disabled device never claims an access
    a_disabled_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && !r_dev_en |=> !o_rsp.handled)
        else $error("access claimed while device disabled");

    // only reads return data
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_in.req_type != REQ_READ |=> o_rsp.read_data == '0)
        else $error("nonzero read data on non-read access");

    // a posted event that is claimed raises the interrupt
    a_event_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && rsp.handled && r_in.req_type == REQ_EVENT |=> o_rsp.irq_level)
        else $error("claimed event did not raise interrupt");

    // response register is loaded only from a held access
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid && !o_rsp.ready && r_out_valid |=> r_out_valid && $stable(r_out))
        else $error("response register changed without an access");
`endif

endmodule

`default_nettype wire

/* hw/rtl/vmir_cfg_space.sv */
`default_nettype none

// Generated input config space: select/subselect/size header plus data bytes.
module vmir_cfg_space (
    input  wire logic [7:0]                   i_sel,
    input  wire logic [7:0]                   i_sub,
    input  wire logic [7:0]                   i_rel,
    input  wire logic [vmir_pkg::SIZE_W-1:0]  i_size,
    output logic      [vmir_pkg::DATA_W-1:0]  o_data
);
    import vmir_pkg::*;

    localparam int NAME_LEN = 17;
    localparam logic [7:0] BTN_NAME [NAME_LEN] = '{
        8'h56, 8'h4d, 8'h4d, 8'h20, 8'h50, 8'h6f, 8'h77, 8'h65, 8'h72,
        8'h20, 8'h42, 8'h75, 8'h74, 8'h74, 8'h6f, 8'h6e, 8'h00
    };
    localparam logic [7:0] SEL_NAME   = 8'h01;
    localparam logic [7:0] SEL_IDS    = 8'h03;
    localparam logic [7:0] SEL_EV_BITS = 8'h11;
    localparam logic [7:0] EV_KEY     = 8'h01;
    localparam logic [7:0] DATA_OFS   = 8'd8;
    localparam logic [7:0] KEY_BYTE   = 8'd22;   // 8 + 116 / 8
    localparam logic [7:0] KEY_MASK   = 8'h10;   // 1 << (116 % 8)

    function automatic logic [7:0] cfg_byte(input logic [7:0] idx,
                                            input logic [7:0] sel,
                                            input logic [7:0] sub);
        logic [7:0] b;
        logic [7:0] ni;
        b  = 8'h00;
        ni = idx - DATA_OFS;
        if (idx == 8'd0) begin
            b = sel;
        end else if (idx == 8'd1) begin
            b = sub;
        end else if (sel == SEL_NAME) begin
            if (idx == 8'd2) begin
                b = 8'd17;
            end else if (idx >= DATA_OFS && idx < DATA_OFS + 8'(NAME_LEN)) begin
                b = BTN_NAME[ni[4:0]];
            end
        end else if (sel == SEL_IDS) begin
            unique case (idx)
                8'd2:         b = 8'd8;
                8'd8:         b = 8'd6;
                8'd10:        b = VENDOR_ID[7:0];
                8'd11:        b = VENDOR_ID[15:8];
                8'd12, 8'd14: b = 8'd1;
                default:      b = 8'h00;
            endcase
        end else if (sel == SEL_EV_BITS && sub == EV_KEY) begin
            if (idx == 8'd2) begin
                b = 8'd15;
            end else if (idx == KEY_BYTE) begin
                b = KEY_MASK;
            end
        end
        return b;
    endfunction

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (SIZE_W'(k) < i_size) begin
                o_data[8*k +: 8] = cfg_byte(i_rel + 8'(k), i_sel, i_sub);
            end else begin
                o_data[8*k +: 8] = 8'h00;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/vmir_regs.sv */
`default_nettype none

// Register file and access decode. Response and next state are combinational;
// state commits on i_fire.
module vmir_regs #(
    parameter int QUEUE_MAX   = 64,
    parameter int QUEUE_COUNT = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic           i_dev_en,
    input  wire vmir_pkg::t_req i_req,
    output vmir_pkg::t_rsp      o_rsp
);
    import vmir_pkg::*;

    localparam int QS_W = $clog2(QUEUE_MAX) + 1;
    localparam int QI_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

    logic [DATA_W-1:0] r_status,    n_status;
    logic              r_int,       n_int;
    logic              r_feat_one,  n_feat_one;
    logic              r_drv_one,   n_drv_one;
    logic              r_qsel_ok,   n_qsel_ok;
    logic [QI_W-1:0]   r_qsel,      n_qsel;
    logic              r_accver,    n_accver;
    logic [7:0]        r_cfg_sel,   n_cfg_sel;
    logic [7:0]        r_cfg_sub,   n_cfg_sub;
    logic [63:0]       r_desc  [QUEUE_COUNT];
    logic [63:0]       n_desc  [QUEUE_COUNT];
    logic [63:0]       r_avail [QUEUE_COUNT];
    logic [63:0]       n_avail [QUEUE_COUNT];
    logic [63:0]       r_used  [QUEUE_COUNT];
    logic [63:0]       n_used  [QUEUE_COUNT];
    logic [QS_W-1:0]   r_q_size  [QUEUE_COUNT];
    logic [QS_W-1:0]   n_q_size  [QUEUE_COUNT];
    logic              r_q_ready [QUEUE_COUNT];
    logic              n_q_ready [QUEUE_COUNT];

    logic [QI_W-1:0]   qi;
    logic [DATA_W-1:0] wd;
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] cfg_data;
    logic [7:0]        rel;
    logic              in_cfg;
    logic              cfg_fits;
    logic              reg_ok;
    logic              ring_ok;
    logic              ok;

    assign qi       = r_qsel_ok ? r_qsel : '0;
    assign wd       = i_req.write_data;
    assign rel      = i_req.offset[7:0];
    assign in_cfg   = (i_req.offset >= CFG_BASE) && (i_req.offset < CFG_END);
    assign cfg_fits = (i_req.access_size <= 4'd4)
                   && ({5'b0, i_req.access_size} <= CFG_BYTES - {1'b0, rel});
    assign reg_ok   = (i_req.access_size == 4'd4) && (i_req.offset[1:0] == 2'b00);
    assign ring_ok  = r_qsel_ok && !r_q_ready[qi];

    vmir_cfg_space u_cfg (
        .i_sel  (r_cfg_sel),
        .i_sub  (r_cfg_sub),
        .i_rel  (rel),
        .i_size (i_req.access_size),
        .o_data (cfg_data)
    );

    always_comb begin
        n_status   = r_status;
        n_int      = r_int;
        n_feat_one = r_feat_one;
        n_drv_one  = r_drv_one;
        n_qsel_ok  = r_qsel_ok;
        n_qsel     = r_qsel;
        n_accver   = r_accver;
        n_cfg_sel  = r_cfg_sel;
        n_cfg_sub  = r_cfg_sub;
        n_desc     = r_desc;
        n_avail    = r_avail;
        n_used     = r_used;
        n_q_size   = r_q_size;
        n_q_ready  = r_q_ready;
        ok         = 1'b0;
        rd         = '0;

        if (i_dev_en) begin
            if (i_req.req_type == REQ_EVENT) begin
                if (r_status[ST_DRIVER_OK] && r_q_ready[0]) begin
                    n_int = 1'b1;
                    ok    = 1'b1;
                end
            end else if (i_req.req_type == REQ_READ || i_req.req_type == REQ_WRITE) begin
                if (in_cfg) begin
                    if (cfg_fits) begin
                        if (i_req.req_type == REQ_WRITE) begin
                            if (i_req.access_size == 4'd1 && rel <= 8'd1) begin
                                ok = 1'b1;
                                if (rel == 8'd0) begin
                                    n_cfg_sel = wd[7:0];
                                end else begin
                                    n_cfg_sub = wd[7:0];
                                end
                            end
                        end else begin
                            ok = 1'b1;
                            rd = cfg_data;
                        end
                    end
                end else if (reg_ok) begin
                    if (i_req.req_type == REQ_READ) begin
                        ok = 1'b1;
                        unique case (i_req.offset)
                            OFF_MAGIC:         rd = MAGIC_VALUE;
                            OFF_VERSION:       rd = MMIO_VER;
                            OFF_DEVICE_ID:     rd = DEVICE_ID;
                            OFF_VENDOR_ID:     rd = VENDOR_ID;
                            OFF_DEV_FEAT:      rd = {31'b0, r_feat_one};
                            OFF_QUEUE_NUM_MAX: rd = r_qsel_ok ? DATA_W'(QUEUE_MAX) : '0;
                            OFF_QUEUE_READY:   rd = {31'b0, r_qsel_ok && r_q_ready[qi]};
                            OFF_INT_STATUS:    rd = {31'b0, r_int};
                            OFF_STATUS:        rd = r_status;
                            OFF_CFG_GEN:       rd = '0;
                            default:           ok = 1'b0;
                        endcase
                    end else begin
                        unique case (i_req.offset)
                            OFF_DEV_FEAT_SEL: begin
                                ok         = 1'b1;
                                n_feat_one = (wd == 32'd1);
                            end
                            OFF_DRV_FEAT_SEL: begin
                                ok        = 1'b1;
                                n_drv_one = (wd == 32'd1);
                            end
                            OFF_DRV_FEAT: begin
                                if (r_drv_one) begin
                                    if (wd[31:1] == '0) begin
                                        ok       = 1'b1;
                                        n_accver = wd[0];
                                    end
                                end else if (wd == '0) begin
                                    ok = 1'b1;
                                end
                            end
                            OFF_QUEUE_SEL: begin
                                ok        = 1'b1;
                                n_qsel_ok = (wd < DATA_W'(QUEUE_COUNT));
                                n_qsel    = wd[QI_W-1:0];
                            end
                            OFF_QUEUE_NUM: begin
                                if (ring_ok && wd != '0 && wd <= DATA_W'(QUEUE_MAX)
                                    && (wd & (wd - 32'd1)) == '0) begin
                                    ok           = 1'b1;
                                    n_q_size[qi] = wd[QS_W-1:0];
                                end
                            end
                            OFF_QUEUE_READY: begin
                                if (r_qsel_ok && wd <= 32'd1
                                    && !(wd[0] && r_q_size[qi] == '0)) begin
                                    ok            = 1'b1;
                                    n_q_ready[qi] = wd[0];
                                end
                            end
                            OFF_QUEUE_NOTIFY: begin
                                ok = (wd <= 32'd1);
                            end
                            OFF_INT_ACK: begin
                                ok    = 1'b1;
                                n_int = r_int & ~wd[0];
                            end
                            OFF_STATUS: begin
                                ok       = 1'b1;
                                n_status = wd;
                                if (wd == '0) begin
                                    for (int q = 0; q < QUEUE_COUNT; q++) begin
                                        n_desc[q]    = '0;
                                        n_avail[q]   = '0;
                                        n_used[q]    = '0;
                                        n_q_size[q]  = '0;
                                        n_q_ready[q] = 1'b0;
                                    end
                                    n_accver = 1'b0;
                                    n_int    = 1'b0;
                                end else if (wd[ST_FEATURES_OK] && !r_accver) begin
                                    n_status[ST_FEATURES_OK] = 1'b0;
                                end
                            end
                            OFF_DESC_LO: begin
                                ok = ring_ok;
                                if (ring_ok) n_desc[qi][31:0] = wd;
                            end
                            OFF_DESC_HI: begin
                                ok = ring_ok;
                                if (ring_ok) n_desc[qi][63:32] = wd;
                            end
                            OFF_AVAIL_LO: begin
                                ok = ring_ok;
                                if (ring_ok) n_avail[qi][31:0] = wd;
                            end
                            OFF_AVAIL_HI: begin
                                ok = ring_ok;
                                if (ring_ok) n_avail[qi][63:32] = wd;
                            end
                            OFF_USED_LO: begin
                                ok = ring_ok;
                                if (ring_ok) n_used[qi][31:0] = wd;
                            end
                            OFF_USED_HI: begin
                                ok = ring_ok;
                                if (ring_ok) n_used[qi][63:32] = wd;
                            end
                            default: ok = 1'b0;
                        endcase
                    end
                end
            end
        end

        o_rsp.handled   = ok;
        o_rsp.read_data = (ok && i_req.req_type == REQ_READ) ? rd : '0;
        o_rsp.irq_level = n_int;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= '0;
            r_int      <= 1'b0;
            r_feat_one <= 1'b0;
            r_drv_one  <= 1'b0;
            r_qsel_ok  <= 1'b1;
            r_qsel     <= '0;
            r_accver   <= 1'b0;
            r_cfg_sel  <= '0;
            r_cfg_sub  <= '0;
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                r_desc[q]    <= '0;
                r_avail[q]   <= '0;
                r_used[q]    <= '0;
                r_q_size[q]  <= '0;
                r_q_ready[q] <= 1'b0;
            end
        end else if (i_fire) begin
            r_status   <= n_status;
            r_int      <= n_int;
            r_feat_one <= n_feat_one;
            r_drv_one  <= n_drv_one;
            r_qsel_ok  <= n_qsel_ok;
            r_qsel     <= n_qsel;
            r_accver   <= n_accver;
            r_cfg_sel  <= n_cfg_sel;
            r_cfg_sub  <= n_cfg_sub;
            r_desc     <= n_desc;
            r_avail    <= n_avail;
            r_used     <= n_used;
            r_q_size   <= n_q_size;
            r_q_ready  <= n_q_ready;
        end
    end

endmodule

`default_nettype wire
